// ----- rtl/core/rip_pkg.sv -----
// Shared types and constants of the radix integer parser.
package rip_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned RadixWidth = 6;
  localparam int unsigned CharWidth  = 8;

  localparam logic [ValueWidth-1:0] LimitWide   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [ValueWidth-1:0] LimitNarrow = 64'h0000_0000_FFFF_FFFF;

  localparam logic [RadixWidth-1:0] RadixReset = 6'd10;
  localparam logic [RadixWidth-1:0] RadixMin   = 6'd2;
  localparam logic [RadixWidth-1:0] RadixMax   = 6'd36;

  localparam logic [CharWidth-1:0] CharMinus  = 8'h2D;
  localparam logic [CharWidth-1:0] CharZero   = 8'h30;
  localparam logic [CharWidth-1:0] CharNine   = 8'h39;
  localparam logic [CharWidth-1:0] CharUpperA = 8'h41;
  localparam logic [CharWidth-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
  localparam logic [CharWidth-1:0] CharLowerZ = 8'h7A;
  localparam logic [CharWidth-1:0] UpperBias  = 8'h37;
  localparam logic [CharWidth-1:0] LowerBias  = 8'h57;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NO_DIGITS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_RADIX  = 2'd0,
    CFG_NARROW = 2'd1,
    CFG_SIGNED = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [RadixWidth-1:0] radix;
    logic                  narrow_mode;
    logic                  signed_mode;
  } cfg_t;

  typedef struct packed {
    logic                  is_minus;
    logic                  digit_ok;
    logic [RadixWidth-1:0] digit;
  } char_info_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    status_e               status;
  } result_t;

endpackage

// ----- rtl/core/rip_if.sv -----
// Valid/ready channel interfaces for characters in and results out.
interface rip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface rip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

// ----- rtl/core/radix_integer_parser.sv -----
// Radix integer parser: one character per beat, one result beat per string, 2 to 36 base.
//
// Characters are taken one per clock, back to back, with no gaps needed; a result
// beat follows the last character through the character and output registers. The rate
// of one character per cycle is set by the accumulator feedback loop: one
// 64x6 multiply, digit add and limit compare between the character register and
// the accumulator. A finished result sits in the output register while the next
// string is taken; the input stalls only when a last character meets a full output
// register. Configuration is written only while idle, by the user; it is not enforced.
module radix_integer_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  rip_in_if.sink            in_bus,
  rip_out_if.source         out_bus,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [5:0]        cfg_data_i
);
  import rip_pkg::*;

  cfg_t                 cfg_q;
  logic                 s1_valid_q, s1_valid_d;
  logic [CharWidth-1:0] s1_char_q;
  logic                 s1_last_q;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q;
  result_t              res;
  logic                 out_free;
  logic                 s1_fire;
  logic                 res_valid;
  logic                 in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix       <= RadixReset;
      cfg_q.narrow_mode <= 1'b0;
      cfg_q.signed_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RADIX:  cfg_q.radix       <= cfg_data_i;
        CFG_NARROW: cfg_q.narrow_mode <= cfg_data_i[0];
        CFG_SIGNED: cfg_q.signed_mode <= cfg_data_i[0];
        default:    cfg_q             <= cfg_q;
      endcase
    end
  end

  assign out_free  = !out_valid_q || out_bus.ready;
  assign s1_fire   = s1_valid_q && (!s1_last_q || out_free);
  assign res_valid = s1_fire && s1_last_q;
  assign in_bus.ready = !s1_valid_q || s1_fire;
  assign in_fire   = in_bus.valid && in_bus.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= in_bus.char_code;
      s1_last_q <= in_bus.last_char;
    end
    if (res_valid) begin
      out_q <= res;
    end
  end

  rip_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_fire),
    .char_i (s1_char_q),
    .last_i (s1_last_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_bus.valid  = out_valid_q;
  assign out_bus.value  = out_q.value;
  assign out_bus.status = out_q.status;

`ifndef NO_ASSERTIONS
  a_value_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |-> (out_q.value == '0))
    else $error("nonzero value with error status");
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free) else $error("result register overwritten");
  a_stalled_char_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_char_q) && $stable(s1_last_q)))
    else $error("stalled character lost");
`endif
endmodule

// ----- rtl/core/rip_char_decode.sv -----
// Character classifier: digit value, base check and minus sign detect.
module rip_char_decode (
  input  logic [7:0]         char_i,
  input  logic [5:0]         base_i,
  output rip_pkg::char_info_t info_o
);
  import rip_pkg::*;

  logic [CharWidth-1:0] diff;
  logic                 is_digit;

  always_comb begin
    diff     = '0;
    is_digit = 1'b0;
    priority if (char_i >= CharZero && char_i <= CharNine) begin
      diff     = char_i - CharZero;
      is_digit = 1'b1;
    end else if (char_i >= CharUpperA && char_i <= CharUpperZ) begin
      diff     = char_i - UpperBias;
      is_digit = 1'b1;
    end else if (char_i >= CharLowerA && char_i <= CharLowerZ) begin
      diff     = char_i - LowerBias;
      is_digit = 1'b1;
    end else begin
      diff     = '0;
      is_digit = 1'b0;
    end
  end

  assign info_o.digit    = diff[RadixWidth-1:0];
  assign info_o.digit_ok = is_digit && (diff[RadixWidth-1:0] < base_i);
  assign info_o.is_minus = (char_i == CharMinus);
endmodule

// ----- rtl/core/rip_accum.sv -----
// Running accumulator, string flags and result formation.
module rip_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  input  rip_pkg::cfg_t       cfg_i,
  output rip_pkg::result_t    res_o
);
  import rip_pkg::*;

  logic [ValueWidth-1:0] acc_q, acc_d;
  logic                  seen_q, seen_d;
  logic                  ovf_q, ovf_d;
  logic                  bad_q, bad_d;
  logic                  neg_q, neg_d;

  logic [RadixWidth-1:0] base;
  logic [ValueWidth-1:0] limit;
  char_info_t            info;
  logic [69:0]           mul;
  logic [70:0]           sum;
  logic                  too_big;
  logic [ValueWidth-1:0] neg_val;

  always_comb begin
    priority if (cfg_i.radix < RadixMin) begin
      base = RadixMin;
    end else if (cfg_i.radix > RadixMax) begin
      base = RadixMax;
    end else begin
      base = cfg_i.radix;
    end
  end

  assign limit = cfg_i.narrow_mode ? LimitNarrow : LimitWide;

  rip_char_decode u_decode (
    .char_i (char_i),
    .base_i (base),
    .info_o (info)
  );

  assign mul     = 70'(acc_q) * 70'(base);
  assign sum     = 71'(mul) + 71'(info.digit);
  assign too_big = sum > 71'(limit);

  always_comb begin
    acc_d  = acc_q;
    seen_d = seen_q;
    ovf_d  = ovf_q;
    bad_d  = bad_q;
    neg_d  = neg_q;
    if (cfg_i.signed_mode && info.is_minus && !seen_q && !bad_q) begin
      neg_d = 1'b1;
    end else if (!info.digit_ok) begin
      bad_d = 1'b1;
    end else if (!bad_q) begin
      seen_d = 1'b1;
      if (ovf_q || too_big) begin
        ovf_d = 1'b1;
      end else begin
        acc_d = sum[ValueWidth-1:0];
      end
    end
  end

  assign neg_val = (ValueWidth'(0) - acc_d) & limit;

  always_comb begin
    res_o.value = '0;
    priority if (bad_d) begin
      res_o.status = ST_BAD_CHAR;
    end else if (ovf_d) begin
      res_o.status = ST_OVERFLOW;
    end else if (!seen_d) begin
      res_o.status = ST_NO_DIGITS;
    end else begin
      res_o.status = ST_OK;
      res_o.value  = (cfg_i.signed_mode && neg_d) ? neg_val : acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      seen_q <= 1'b0;
      ovf_q  <= 1'b0;
      bad_q  <= 1'b0;
      neg_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        acc_q  <= '0;
        seen_q <= 1'b0;
        ovf_q  <= 1'b0;
        bad_q  <= 1'b0;
        neg_q  <= 1'b0;
      end else begin
        acc_q  <= acc_d;
        seen_q <= seen_d;
        ovf_q  <= ovf_d;
        bad_q  <= bad_d;
        neg_q  <= neg_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ovf_needs_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> seen_q) else $error("overflow flagged without a digit");
`endif
endmodule
